### rtl/core/psf_pkg.sv
`default_nettype none
package psf_pkg;
    localparam int unsigned PosW   = 32;
    localparam int unsigned DiffW  = 33;
    localparam int unsigned SqW    = 66;
    localparam int unsigned LenW   = 33;
    localparam int unsigned RegW   = 31;
    localparam int unsigned MagW   = 48;
    localparam int unsigned ProdW  = 81;
    localparam int unsigned SqrtStg = 33;
    localparam int unsigned DivStg  = 32;
    localparam int unsigned Latency = 4 + SqrtStg + 6 + DivStg + 1;

    localparam logic [1:0] MODE_ATTRACT = 2'd0;
    localparam logic [1:0] MODE_HOOKE   = 2'd1;
    localparam logic [1:0] MODE_BUNGEE  = 2'd2;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_REST = 2'd1;
    localparam logic [1:0] CFG_K    = 2'd2;
    localparam logic [1:0] CFG_NONE = 2'd3;

    localparam logic [RegW-1:0] REST_RESET = 31'd65536;
    localparam logic [RegW-1:0] K_RESET    = 31'd65536;

    localparam logic [PosW-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [PosW-1:0] NEG_MIN = 32'h8000_0000;
endpackage
`default_nettype wire

### rtl/core/particle_spring_force.sv
// particle_spring_force
// Spring force on one particle from one other end (far particle or anchor).
// Input channel: six signed Q16.16 coordinates, transfer on i_in_valid &
// o_in_ready. Output channel: force x/y/z (signed Q16.16, clipped) and a
// saturated flag, transfer on o_out_valid & i_out_ready.
// Config channel: index 0 mode, 1 rest length, 2 spring constant; always
// ready, an index of 3 is dropped. Write only while the pipeline is empty.
// Pipeline from input transfer to output valid: four stages up to
// the radicand, 33 square root stages (two radicand bits each), six stages
// up to the divider set-up, 32 divider stages (one quotient bit each) and
// the output stage.
// Throughput: one item per cycle unless the output stalls, fully pipelined.
// The whole pipeline advances together; when the output is held and not
// taken, every stage holds and o_in_ready drops, nothing is lost.
// Reset clears all valid bits and loads mode 1, rest length 1.0 and spring
// constant 1.0.
`default_nettype none
module particle_spring_force
    import psf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [31:0]     i_particle_x,
    input  wire logic [31:0]     i_particle_y,
    input  wire logic [31:0]     i_particle_z,
    input  wire logic [31:0]     i_other_x,
    input  wire logic [31:0]     i_other_y,
    input  wire logic [31:0]     i_other_z,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [31:0]          o_force_x,
    output logic [31:0]          o_force_y,
    output logic [31:0]          o_force_z,
    output logic                 o_saturated,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data
);
    logic                en;
    logic [Latency-1:0]  r_vld;
    logic [1:0]          r_mode;
    logic [RegW-1:0]     r_rest;
    logic [RegW-1:0]     r_k;

    assign en          = !r_vld[Latency-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[Latency-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Latency-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HOOKE;
            r_rest <= REST_RESET;
            r_k    <= K_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode <= i_cfg_data[1:0];
                CFG_REST: r_rest <= i_cfg_data[RegW-1:0];
                CFG_K:    r_k    <= i_cfg_data[RegW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: difference and magnitude
    logic [PosW-1:0]  pin [3];
    logic [PosW-1:0]  oin [3];
    logic [DiffW-1:0] r1_ad [3];
    logic [2:0]       r1_neg;

    assign pin[0] = i_particle_x;
    assign pin[1] = i_particle_y;
    assign pin[2] = i_particle_z;
    assign oin[0] = i_other_x;
    assign oin[1] = i_other_y;
    assign oin[2] = i_other_z;

    always_ff @(posedge i_clk) begin
        logic [DiffW-1:0] d;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d = {pin[i][PosW-1], pin[i]} - {oin[i][PosW-1], oin[i]};
                r1_ad[i]  <= d[DiffW-1] ? (~d + 1'b1) : d;
                r1_neg[i] <= d[DiffW-1];
            end
        end
    end

    // stage 2: partial squares
    logic [33:0]      r2_hh [3];
    logic [32:0]      r2_hl [3];
    logic [31:0]      r2_ll [3];
    logic [DiffW-1:0] r2_ad [3];
    logic [2:0]       r2_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_hh[i] <= r1_ad[i][32:16] * r1_ad[i][32:16];
                r2_hl[i] <= r1_ad[i][32:16] * r1_ad[i][15:0];
                r2_ll[i] <= r1_ad[i][15:0] * r1_ad[i][15:0];
                r2_ad[i] <= r1_ad[i];
            end
            r2_neg <= r1_neg;
        end
    end

    // stage 3: squares
    logic [SqW-1:0]   r3_sq [3];
    logic [DiffW-1:0] r3_ad [3];
    logic [2:0]       r3_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= {r2_hh[i], 32'd0} + {16'd0, r2_hl[i], 17'd0}
                          + {34'd0, r2_ll[i]};
                r3_ad[i] <= r2_ad[i];
            end
            r3_neg <= r2_neg;
        end
    end

    // stage 4 and square root pipeline, two radicand bits per stage
    logic [SqW-1:0]   r_sq_s    [SqrtStg+1];
    logic [LenW-1:0]  r_sq_root [SqrtStg+1];
    logic [34:0]      r_sq_rem  [SqrtStg+1];
    logic [DiffW-1:0] r_sq_ad   [SqrtStg+1][3];
    logic [2:0]       r_sq_neg  [SqrtStg+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_s[0]    <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            r_sq_root[0] <= '0;
            r_sq_rem[0]  <= '0;
            for (int i = 0; i < 3; i++) r_sq_ad[0][i] <= r3_ad[i];
            r_sq_neg[0]  <= r3_neg;
        end
    end

    for (genvar k = 0; k < SqrtStg; k++) begin : g_sqrt
        logic [36:0] t;
        logic [36:0] trial;
        logic        ge;

        assign t     = {r_sq_rem[k], r_sq_s[k][SqW-1:SqW-2]};
        assign trial = {2'b00, r_sq_root[k], 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            logic [36:0] diff;
            if (en) begin
                diff = t - trial;
                r_sq_s[k+1]    <= {r_sq_s[k][SqW-3:0], 2'b00};
                r_sq_root[k+1] <= {r_sq_root[k][LenW-2:0], ge};
                r_sq_rem[k+1]  <= ge ? diff[34:0] : t[34:0];
                for (int i = 0; i < 3; i++) r_sq_ad[k+1][i] <= r_sq_ad[k][i];
                r_sq_neg[k+1]  <= r_sq_neg[k];
            end
        end
    end

    logic [LenW-1:0] len;
    assign len = r_sq_root[SqrtStg];

    // stage 5: extension by mode
    logic [LenW-1:0]  r5_eabs;
    logic             r5_pos;
    logic             r5_zero;
    logic [LenW-1:0]  r5_len;
    logic [DiffW-1:0] r5_ad [3];
    logic [2:0]       r5_neg;

    always_ff @(posedge i_clk) begin
        logic [34:0] ext;
        logic [34:0] eff;
        logic [34:0] mag;
        if (en) begin
            ext = {2'b00, len} - {4'd0, r_rest};
            case (r_mode)
                MODE_ATTRACT: eff = ext[34] ? (~ext + 1'b1) : ext;
                MODE_HOOKE:   eff = ext;
                MODE_BUNGEE:  eff = (!ext[34] && ext != '0) ? ext : '0;
                default:      eff = '0;
            endcase
            mag = eff[34] ? (~eff + 1'b1) : eff;
            r5_eabs <= mag[LenW-1:0];
            r5_pos  <= !eff[34];
            r5_zero <= (len == '0) || (eff == '0);
            r5_len  <= len;
            for (int i = 0; i < 3; i++) r5_ad[i] <= r_sq_ad[SqrtStg][i];
            r5_neg  <= r_sq_neg[SqrtStg];
        end
    end

    // stage 6: extension times stiffness, low part
    logic [62:0]      r6_p;
    logic             r6_hi;
    logic             r6_pos;
    logic             r6_zero;
    logic [LenW-1:0]  r6_len;
    logic [DiffW-1:0] r6_ad [3];
    logic [2:0]       r6_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_p    <= r5_eabs[31:0] * r_k;
            r6_hi   <= r5_eabs[32];
            r6_pos  <= r5_pos;
            r6_zero <= r5_zero;
            r6_len  <= r5_len;
            for (int i = 0; i < 3; i++) r6_ad[i] <= r5_ad[i];
            r6_neg  <= r5_neg;
        end
    end

    // stage 7: magnitude
    logic [MagW-1:0]  r7_mag;
    logic             r7_pos;
    logic             r7_zero;
    logic [LenW-1:0]  r7_len;
    logic [DiffW-1:0] r7_ad [3];
    logic [2:0]       r7_neg;

    always_ff @(posedge i_clk) begin
        logic [63:0] sum;
        if (en) begin
            sum = {1'b0, r6_p} + (r6_hi ? {1'b0, r_k, 32'd0} : 64'd0);
            r7_mag  <= sum[63:16];
            r7_pos  <= r6_pos;
            r7_zero <= r6_zero;
            r7_len  <= r6_len;
            for (int i = 0; i < 3; i++) r7_ad[i] <= r6_ad[i];
            r7_neg  <= r6_neg;
        end
    end

    // stage 8: magnitude times axis, partial products
    logic [63:0]      r8_pp0 [3];
    logic [47:0]      r8_pp1 [3];
    logic [2:0]       r8_ah;
    logic [MagW-1:0]  r8_mag;
    logic             r8_pos;
    logic             r8_zero;
    logic [LenW-1:0]  r8_len;
    logic [2:0]       r8_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_pp0[i] <= r7_mag[31:0] * r7_ad[i][31:0];
                r8_pp1[i] <= r7_mag[47:32] * r7_ad[i][31:0];
                r8_ah[i]  <= r7_ad[i][32];
            end
            r8_mag  <= r7_mag;
            r8_pos  <= r7_pos;
            r8_zero <= r7_zero;
            r8_len  <= r7_len;
            r8_neg  <= r7_neg;
        end
    end

    // stage 9: dividend
    logic [ProdW-1:0] r9_n [3];
    logic             r9_pos;
    logic             r9_zero;
    logic [LenW-1:0]  r9_len;
    logic [2:0]       r9_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r9_n[i] <= {17'd0, r8_pp0[i]} + {1'b0, r8_pp1[i], 32'd0}
                         + (r8_ah[i] ? {1'b0, r8_mag, 32'd0} : '0);
            end
            r9_pos  <= r8_pos;
            r9_zero <= r8_zero;
            r9_len  <= r8_len;
            r9_neg  <= r8_neg;
        end
    end

    // stage 10 and divider pipeline, one quotient bit per stage
    logic [LenW-1:0] r_dv_rem [DivStg+1][3];
    logic [31:0]     r_dv_low [DivStg+1][3];
    logic [31:0]     r_dv_q   [DivStg+1][3];
    logic [2:0]      r_dv_ovf [DivStg+1];
    logic [2:0]      r_dv_neg [DivStg+1];
    logic            r_dv_pos [DivStg+1];
    logic            r_dv_zero[DivStg+1];
    logic [LenW-1:0] r_dv_len [DivStg+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_ovf[0][i] <= (r9_n[i][ProdW-1:32] >= {16'd0, r9_len});
                r_dv_rem[0][i] <= r9_n[i][64:32];
                r_dv_low[0][i] <= r9_n[i][31:0];
                r_dv_q[0][i]   <= '0;
            end
            r_dv_neg[0]  <= r9_neg;
            r_dv_pos[0]  <= r9_pos;
            r_dv_zero[0] <= r9_zero;
            r_dv_len[0]  <= r9_len;
        end
    end

    for (genvar k = 0; k < DivStg; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [LenW:0] t;
            logic [LenW:0] diff;
            logic          ge;
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    t    = {r_dv_rem[k][i], r_dv_low[k][i][31]};
                    diff = t - {1'b0, r_dv_len[k]};
                    ge   = (t >= {1'b0, r_dv_len[k]});
                    r_dv_rem[k+1][i] <= ge ? diff[LenW-1:0] : t[LenW-1:0];
                    r_dv_low[k+1][i] <= {r_dv_low[k][i][30:0], 1'b0};
                    r_dv_q[k+1][i]   <= {r_dv_q[k][i][30:0], ge};
                end
                r_dv_ovf[k+1]  <= r_dv_ovf[k];
                r_dv_neg[k+1]  <= r_dv_neg[k];
                r_dv_pos[k+1]  <= r_dv_pos[k];
                r_dv_zero[k+1] <= r_dv_zero[k];
                r_dv_len[k+1]  <= r_dv_len[k];
            end
        end
    end

    // output stage: sign and clipping
    logic [31:0] r_f [3];
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        logic [31:0] q;
        logic        neg;
        logic        clip;
        logic        any;
        if (en) begin
            any = 1'b0;
            for (int i = 0; i < 3; i++) begin
                q    = r_dv_q[DivStg][i];
                neg  = r_dv_pos[DivStg] != r_dv_neg[DivStg][i];
                if (r_dv_zero[DivStg]) begin
                    r_f[i] <= '0;
                end else if (neg) begin
                    clip = r_dv_ovf[DivStg][i] || (q > NEG_MIN);
                    r_f[i] <= clip ? NEG_MIN : (~q + 1'b1);
                    any = any | clip;
                end else begin
                    clip = r_dv_ovf[DivStg][i] || q[31];
                    r_f[i] <= clip ? POS_MAX : q;
                    any = any | clip;
                end
            end
            r_sat <= any;
        end
    end

    assign o_force_x   = r_f[0];
    assign o_force_y   = r_f[1];
    assign o_force_z   = r_f[2];
    assign o_saturated = r_sat;

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_force_x == POS_MAX) || (o_force_x == NEG_MIN) ||
            (o_force_y == POS_MAX) || (o_force_y == NEG_MIN) ||
            (o_force_z == POS_MAX) || (o_force_z == NEG_MIN))
        else $error("saturated flag without clipped component");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("transfer did not enter pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[Latency-2] && r_dv_zero[DivStg] && en |=>
            !o_saturated && (o_force_x == '0) && (o_force_y == '0) && (o_force_z == '0))
        else $error("zero force case gave non-zero output");
endmodule
`default_nettype wire

### dv/particle_spring_force_tb.sv
`timescale 1ns / 1ps
`default_nettype none

class spring_force_board;
    logic [1:0]  mode;
    logic [30:0] rest;
    logic [30:0] stiff;
    logic [31:0] want_fx[$];
    logic [31:0] want_fy[$];
    logic [31:0] want_fz[$];
    logic        want_sat[$];
    int          errors;

    function new();
        mode   = psf_pkg::MODE_HOOKE;
        rest   = psf_pkg::REST_RESET;
        stiff  = psf_pkg::K_RESET;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == psf_pkg::CFG_MODE) mode = val[1:0];
        else if (idx == psf_pkg::CFG_REST) rest = val[30:0];
        else if (idx == psf_pkg::CFG_K) stiff = val[30:0];
    endfunction

    // floor(sqrt(s)) over 36 result bits
    function logic [35:0] isqrt(logic [67:0] s);
        logic [35:0]  r;
        logic [35:0]  c;
        logic [71:0]  sq;
        r = '0;
        for (int b = 35; b >= 0; b--) begin
            c  = r | (36'd1 << b);
            sq = {36'd0, c} * {36'd0, c};
            if (sq <= {4'd0, s}) r = c;
        end
        return r;
    endfunction

    function void add_expected(logic [31:0] f[3], logic sat);
        want_fx  = {want_fx, f[0]};
        want_fy  = {want_fy, f[1]};
        want_fz  = {want_fz, f[2]};
        want_sat = {want_sat, sat};
    endfunction

    function void note_input(logic [31:0] p[3], logic [31:0] o[3]);
        logic signed [33:0] d[3];
        logic [33:0]        ad[3];
        logic [67:0]        s;
        logic [35:0]        len;
        logic signed [37:0] ext;
        logic signed [37:0] eff;
        logic [37:0]        aeff;
        logic [69:0]        mag;
        logic [127:0]       q;
        logic [31:0]        f[3];
        logic               sat;
        logic               neg;
        s   = '0;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d[i]  = $signed({{2{p[i][31]}}, p[i]}) - $signed({{2{o[i][31]}}, o[i]});
            ad[i] = d[i] < 0 ? -d[i] : d[i];
            s     = s + {34'd0, ad[i]} * {34'd0, ad[i]};
        end
        len = isqrt(s);
        ext = $signed({2'b0, len}) - $signed({7'b0, rest});
        case (mode)
            psf_pkg::MODE_ATTRACT: eff = ext < 0 ? -ext : ext;
            psf_pkg::MODE_HOOKE:   eff = ext;
            psf_pkg::MODE_BUNGEE:  eff = ext > 0 ? ext : 38'sd0;
            default:               eff = '0;
        endcase
        for (int i = 0; i < 3; i++) f[i] = '0;
        if (len != 0 && eff != 0) begin
            aeff = eff < 0 ? -eff : eff;
            mag  = ({32'd0, aeff} * {39'd0, stiff}) >> 16;
            for (int i = 0; i < 3; i++) begin
                q   = ({58'd0, mag} * {94'd0, ad[i]}) / {92'd0, len};
                neg = (eff > 0) != (d[i] < 0);
                if (q == 0) begin
                    f[i] = '0;
                end else if (neg) begin
                    if (q > 128'h8000_0000) begin
                        q   = 128'h8000_0000;
                        sat = 1'b1;
                    end
                    f[i] = -q[31:0];
                end else begin
                    if (q > 128'h7FFF_FFFF) begin
                        q   = 128'h7FFF_FFFF;
                        sat = 1'b1;
                    end
                    f[i] = q[31:0];
                end
            end
        end
        add_expected(f, sat);
    endfunction

    function void check_result(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                               logic sat);
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic        es;
        if (want_fx.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
        end
        ex = want_fx.pop_front();
        ey = want_fy.pop_front();
        ez = want_fz.pop_front();
        es = want_sat.pop_front();
        if (fx !== ex) begin
            $error("force_x expected %h got %h", ex, fx);
            errors++;
        end
        if (fy !== ey) begin
            $error("force_y expected %h got %h", ey, fy);
            errors++;
        end
        if (fz !== ez) begin
            $error("force_z expected %h got %h", ez, fz);
            errors++;
        end
        if (sat !== es) begin
            $error("saturated expected %b got %b", es, sat);
            errors++;
        end
    endfunction

    function int pending();
        return want_fx.size();
    endfunction
endclass

module particle_spring_force_tb;
    import psf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] px, py, pz, ox, oy, oz;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] fx, fy, fz;
    logic        sat;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    spring_force_board board;
    int send_idle_pct;
    int recv_idle_pct;
    longint cycles;

    particle_spring_force u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_particle_x (px),
        .i_particle_y (py),
        .i_particle_z (pz),
        .i_other_x    (ox),
        .i_other_y    (oy),
        .i_other_z    (oz),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_force_x    (fx),
        .o_force_y    (fy),
        .o_force_z    (fz),
        .o_saturated  (sat),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        board         = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cycles        = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check transfers and randomise ready
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_result(fx, fy, fz, sat);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (Latency + 8) @(posedge clk);
    endtask

    task automatic send(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                        logic [31:0] d, logic [31:0] e, logic [31:0] f);
        logic [31:0] p[3];
        logic [31:0] o[3];
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        px <= a; py <= b; pz <= c;
        ox <= d; oy <= e; oz <= f;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = '{a, b, c};
        o = '{d, e, f};
        board.note_input(p, o);
    endtask

    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return 32'($signed($urandom_range(400)) - 200) << 16;
            default: begin
                case ($urandom_range(3))
                    0: return POS_MAX;
                    1: return NEG_MIN;
                    2: return 32'd0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic random_items(int n);
        int k;
        logic [31:0] a, b, c;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(9);
            if (k < 5) k = 1; else if (k < 7) k = 2; else if (k < 9) k = 0; else k = 3;
            a = rand_coord(k); b = rand_coord(k); c = rand_coord(k);
            if ($urandom_range(19) == 0)
                send(a, b, c, a, b, c);
            else
                send(a, b, c, rand_coord(k), rand_coord(k), rand_coord(k));
        end
    endtask

    task automatic random_config();
        case ($urandom_range(3))
            0: write_reg(CFG_MODE, {$urandom()} & 32'hFFFF_FFFC | 32'($urandom_range(3)));
            1: write_reg(CFG_REST, $urandom_range(3) == 0 ? $urandom() :
                         32'($urandom_range(4 << 16)));
            2: write_reg(CFG_K, $urandom_range(3) == 0 ? $urandom() :
                         32'($urandom_range(8 << 16)));
            default: write_reg(CFG_NONE, $urandom());
        endcase
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        {px, py, pz, ox, oy, oz} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting, then each mode
        send(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
        send(0, 0, 0, 0, 0, 0);
        send(32'h0000_8000, 0, 0, 0, 0, 0);
        send(POS_MAX, POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, NEG_MIN);
        send(NEG_MIN, 0, POS_MAX, POS_MAX, 0, NEG_MIN);
        send(32'h0001_0000, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_K, 32'hFFFF_FFFF);
        send(POS_MAX, 0, 0, NEG_MIN, 0, 0);
        send(0, 0, 0, 0, 0, 32'h0000_0001);
        drain();
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_MODE, 32'hFFFF_FFFC | m);
            write_reg(CFG_REST, m == 3 ? 32'hFFFF_FFFF : 32'h0002_0000);
            write_reg(CFG_K, 32'h0003_0000);
            send(32'h0001_0000, 0, 0, 0, 0, 0);
            send(32'h0005_0000, 32'hFFFD_0000, 0, 0, 0, 32'h0001_0000);
            send(32'h0002_0000, 0, 0, 0, 0, 0);
            send(POS_MAX, NEG_MIN, 0, NEG_MIN, POS_MAX, 0);
            drain();
        end
        write_reg(CFG_REST, 0);
        write_reg(CFG_K, 0);
        write_reg(CFG_NONE, 32'h1234_5678);
        send(32'h0001_0000, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 16 : ph == 1 ? 52 : 0;
            recv_idle_pct = ph == 0 ? 52 : ph == 1 ? 16 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                random_config();
                random_config();
                random_items(66);
                drain();
            end
        end

        drain();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire
